FILE: rtl/evu_pkg.sv
package evu_pkg;

	localparam int VelW   = 24;
	localparam int DistW  = 24;
	localparam int ViscW  = 32;
	localparam int RelaxW = 17;
	localparam int ConstW = 16;
	localparam int KdW    = ConstW + DistW;
	localparam int SqW    = 2 * VelW;
	localparam int RootW  = VelW;
	localparam int IdxW   = 2;
	localparam int HalfKdW = KdW / 2;

	localparam logic [IdxW-1:0] REG_RELAX = 2'd0;
	localparam logic [IdxW-1:0] REG_PROP  = 2'd1;

	localparam logic [RelaxW-1:0] ONE_Q16   = 17'd65536;
	localparam logic [RelaxW-1:0] RELAX_RST = 17'd65536;
	localparam logic [ConstW-1:0] PROP_RST  = 16'd2539;

	typedef struct packed {
		logic [KdW-1:0]   kd;
		logic [ViscW-1:0] old;
	} side_t;

	function automatic logic [VelW-1:0] abs_vel(input logic signed [VelW-1:0] v);
		logic [VelW-1:0] res;
		res = v[VelW-1] ? VelW'(-v) : VelW'(v);
		return res;
	endfunction

endpackage

FILE: rtl/evu_sumsq.sv
module evu_sumsq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic signed [evu_pkg::VelW-1:0]   vel_x,
	input  logic signed [evu_pkg::VelW-1:0]   vel_y,
	input  logic signed [evu_pkg::VelW-1:0]   vel_z,
	input  logic        [evu_pkg::DistW-1:0]  wall_dist,
	input  logic        [evu_pkg::ViscW-1:0]  old_visc,
	input  logic        [evu_pkg::ConstW-1:0] prop_const,
	output logic                              vld_o,
	output logic        [evu_pkg::SqW-1:0]    sumsq,
	output evu_pkg::side_t                    side
);
	import evu_pkg::*;

	logic            vld_s1, vld_s2, vld_s3;
	logic [VelW-1:0] ax_s1, ay_s1, az_s1;
	side_t           side_s1, side_s2, side_s3;
	logic [SqW-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [SqW-1:0]  sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1       <= abs_vel(vel_x);
			ay_s1       <= abs_vel(vel_y);
			az_s1       <= abs_vel(vel_z);
			side_s1.kd  <= {{(KdW-ConstW){1'b0}}, prop_const} * {{(KdW-DistW){1'b0}}, wall_dist};
			side_s1.old <= old_visc;

			sqx_s2  <= {{(SqW-VelW){1'b0}}, ax_s1} * {{(SqW-VelW){1'b0}}, ax_s1};
			sqy_s2  <= {{(SqW-VelW){1'b0}}, ay_s1} * {{(SqW-VelW){1'b0}}, ay_s1};
			sqz_s2  <= {{(SqW-VelW){1'b0}}, az_s1} * {{(SqW-VelW){1'b0}}, az_s1};
			side_s2 <= side_s1;

			sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
			side_s3 <= side_s2;
		end
	end

	assign vld_o = vld_s3;
	assign sumsq = sum_s3;
	assign side  = side_s3;

endmodule

FILE: rtl/evu_sqrt.sv
module evu_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  logic        [evu_pkg::SqW-1:0]  rad,
	input  evu_pkg::side_t                  side_i,
	output logic                            vld_o,
	output logic        [evu_pkg::RootW-1:0] root,
	output evu_pkg::side_t                  side_o
);
	import evu_pkg::*;

	logic [SqW-1:0]   rem_s  [RootW+1];
	logic [RootW-1:0] root_s [RootW+1];
	logic             vld_s  [RootW+1];
	side_t            side_s [RootW+1];

	assign rem_s[0]  = rad;
	assign root_s[0] = '0;
	assign vld_s[0]  = vld_i;
	assign side_s[0] = side_i;

	// one root bit per stage, most significant first
	for (genvar k = 0; k < RootW; k++) begin : g_bit
		localparam int B = RootW - 1 - k;
		logic [SqW+1:0] term;
		logic           ge;

		assign term = ({{(SqW+2-RootW){1'b0}}, root_s[k]} << (B + 1))
			| ((SqW+2)'(1) << (2 * B));
		assign ge   = {2'b00, rem_s[k]} >= term;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_s[k] - term[SqW-1:0] : rem_s[k];
				root_s[k+1] <= ge ? root_s[k] | (RootW'(1) << B) : root_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_o  = vld_s[RootW];
	assign root   = root_s[RootW];
	assign side_o = side_s[RootW];

endmodule

FILE: rtl/evu_blend.sv
module evu_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic        [evu_pkg::RootW-1:0]  speed,
	input  evu_pkg::side_t                    side,
	input  logic        [evu_pkg::RelaxW-1:0] relax_factor,
	output logic                              vld_o,
	output logic        [evu_pkg::ViscW-1:0]  new_visc,
	output logic                              saturated
);
	import evu_pkg::*;

	localparam int PartW = HalfKdW + RootW;
	localparam int ProdW = KdW + RootW;
	localparam int MulW  = RelaxW + ViscW;
	localparam int AccW  = MulW + 1;
	localparam int BlW   = AccW - 16;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PartW-1:0]    plo_s1, phi_s1;
	logic [ViscW-1:0]    old_s1, old_s2;
	logic [ViscW-1:0]    tgt_s2;
	logic [MulW-1:0]     m0_s3, m1_s3;
	logic [ViscW-1:0]    visc_s4;
	logic                sat_s4;
	logic [ProdW-1:0]    prod;
	logic [RelaxW-1:0]   r_sat;
	logic [RelaxW-1:0]   r_inv;
	logic [AccW-1:0]     acc;
	logic [BlW-1:0]      blend;

	assign prod  = ({{(ProdW-PartW){1'b0}}, phi_s1} << HalfKdW)
		+ {{(ProdW-PartW){1'b0}}, plo_s1};
	assign r_sat = (relax_factor > ONE_Q16) ? ONE_Q16 : relax_factor;
	assign r_inv = ONE_Q16 - r_sat;
	assign acc   = {1'b0, m0_s3} + {1'b0, m1_s3} + AccW'(32768);
	assign blend = acc[AccW-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= {{RootW{1'b0}}, side.kd[HalfKdW-1:0]}
				* {{HalfKdW{1'b0}}, speed};
			phi_s1 <= {{RootW{1'b0}}, side.kd[KdW-1:HalfKdW]}
				* {{HalfKdW{1'b0}}, speed};
			old_s1 <= side.old;

			tgt_s2 <= prod[ProdW-1:ProdW-ViscW];
			old_s2 <= old_s1;

			m0_s3  <= {{ViscW{1'b0}}, r_inv} * {{RelaxW{1'b0}}, old_s2};
			m1_s3  <= {{ViscW{1'b0}}, r_sat} * {{RelaxW{1'b0}}, tgt_s2};

			sat_s4  <= |blend[BlW-1:ViscW];
			visc_s4 <= (|blend[BlW-1:ViscW]) ? '1 : blend[ViscW-1:0];
		end
	end

	assign vld_o     = vld_s4;
	assign new_visc  = visc_s4;
	assign saturated = sat_s4;

endmodule

FILE: rtl/eddy_viscosity_update.sv
// Pipeline from request accept to result valid: 3 square-sum stages,
// 24 square-root stages at one bit each, 4 target and blend stages.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset: arst_n clears all valid bits, relax_factor to 1.0 and
// prop_const to 2539.
module eddy_viscosity_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [evu_pkg::VelW-1:0]   vel_x,
	input  logic signed [evu_pkg::VelW-1:0]   vel_y,
	input  logic signed [evu_pkg::VelW-1:0]   vel_z,
	input  logic        [evu_pkg::DistW-1:0]  wall_dist,
	input  logic        [evu_pkg::ViscW-1:0]  old_visc,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic        [evu_pkg::ViscW-1:0]  new_visc,
	output logic                              saturated,
	input  logic                              cfg_we,
	input  logic        [evu_pkg::IdxW-1:0]   cfg_idx,
	input  logic        [evu_pkg::RelaxW-1:0] cfg_wdata
);
	import evu_pkg::*;

	logic              en;
	logic [RelaxW-1:0] relax_q;
	logic [ConstW-1:0] prop_q;
	logic              sq_vld, rt_vld;
	logic [SqW-1:0]    sumsq;
	side_t             sq_side, rt_side;
	logic [RootW-1:0]  speed;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= RELAX_RST;
			prop_q  <= PROP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RELAX: relax_q <= cfg_wdata;
				REG_PROP:  prop_q  <= cfg_wdata[ConstW-1:0];
				default:   ;
			endcase
		end
	end

	evu_sumsq u_sumsq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_i      (in_valid),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.wall_dist  (wall_dist),
		.old_visc   (old_visc),
		.prop_const (prop_q),
		.vld_o      (sq_vld),
		.sumsq      (sumsq),
		.side       (sq_side)
	);

	evu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (sq_vld),
		.rad    (sumsq),
		.side_i (sq_side),
		.vld_o  (rt_vld),
		.root   (speed),
		.side_o (rt_side)
	);

	evu_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_i        (rt_vld),
		.speed        (speed),
		.side         (rt_side),
		.relax_factor (relax_q),
		.vld_o        (out_valid),
		.new_visc     (new_visc),
		.saturated    (saturated)
	);

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import evu_pkg::*;

	localparam int PIPE_LAT    = 31;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	// indexes with no register behind them
	localparam logic [IdxW-1:0] REG_SPARE2 = 2'd2;
	localparam logic [IdxW-1:0] REG_SPARE3 = 2'd3;

	typedef struct packed {
		logic signed [VelW-1:0] vx;
		logic signed [VelW-1:0] vy;
		logic signed [VelW-1:0] vz;
		logic [DistW-1:0]       wdist;
		logic [ViscW-1:0]       old;
	} cell_req_t;

	typedef struct packed {
		logic [ViscW-1:0] visc;
		logic             sat;
	} visc_res_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [VelW-1:0]   vel_x;
	logic signed [VelW-1:0]   vel_y;
	logic signed [VelW-1:0]   vel_z;
	logic [DistW-1:0]         wall_dist;
	logic [ViscW-1:0]         old_visc;
	logic                     out_valid;
	logic                     out_ready;
	logic [ViscW-1:0]         new_visc;
	logic                     saturated;
	logic                     cfg_we;
	logic [IdxW-1:0]          cfg_idx;
	logic [RelaxW-1:0]        cfg_wdata;

	logic [RelaxW-1:0] relax_q;
	logic [ConstW-1:0] prop_q;

	visc_res_t visc_expected[$];
	visc_res_t head_res;
	int        mismatches;
	int        cells_sent;
	int        cells_checked;
	int        reg_writes;
	int        idle_cycles;
	bit        tx_gaps;
	bit        rx_gaps;
	logic      hold_req;

	eddy_viscosity_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.wall_dist (wall_dist),
		.old_visc  (old_visc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_visc  (new_visc),
		.saturated (saturated),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [VelW-1:0] vel_mag(input logic signed [VelW-1:0] v);
		logic [VelW-1:0] u;
		u = v;
		return v[VelW-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic logic [RootW-1:0] floor_root(input logic [SqW-1:0] x);
		logic [RootW-1:0] res;
		logic [RootW-1:0] trial;
		logic [SqW-1:0]   sq;
		res = '0;
		for (int i = RootW - 1; i >= 0; i--) begin
			trial = res | (RootW'(1) << i);
			sq = {{(SqW-RootW){1'b0}}, trial} * {{(SqW-RootW){1'b0}}, trial};
			if (sq <= x)
				res = trial;
		end
		return res;
	endfunction

	function automatic visc_res_t predict_visc(input cell_req_t c);
		logic [63:0] ax, ay, az, sumsq, speed, kd, target, r, blend;
		visc_res_t   res;
		ax = 64'(vel_mag(c.vx));
		ay = 64'(vel_mag(c.vy));
		az = 64'(vel_mag(c.vz));
		sumsq = ax * ax + ay * ay + az * az;
		speed = 64'(floor_root(sumsq[SqW-1:0]));
		kd = 64'(prop_q) * 64'(c.wdist);
		target = (kd * speed) >> 32;
		r = (relax_q > ONE_Q16) ? 64'(ONE_Q16) : 64'(relax_q);
		blend = ((64'd65536 - r) * 64'(c.old) + r * target + 64'd32768) >> 16;
		res.sat = blend > 64'hFFFF_FFFF;
		res.visc = res.sat ? 32'hFFFF_FFFF : blend[31:0];
		return res;
	endfunction

	function automatic cell_req_t mk_cell(input logic signed [VelW-1:0] vx,
			input logic signed [VelW-1:0] vy, input logic signed [VelW-1:0] vz,
			input logic [DistW-1:0] d, input logic [ViscW-1:0] o);
		cell_req_t c;
		c.vx = vx;
		c.vy = vy;
		c.vz = vz;
		c.wdist = d;
		c.old = o;
		return c;
	endfunction

	function automatic logic signed [VelW-1:0] rand_vel();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 5))
			0: return w[16] ? -$signed(VelW'(w[15:0])) : $signed(VelW'(w[15:0]));
			1: return w[0] ? 24'sh800000 : 24'sh7FFFFF;
			2: return '0;
			default: return w[VelW-1:0];
		endcase
	endfunction

	function automatic cell_req_t rand_cell();
		cell_req_t   c;
		logic [31:0] w;
		c.vx = rand_vel();
		c.vy = rand_vel();
		c.vz = rand_vel();
		w = $urandom;
		case ($urandom_range(0, 4))
			0: c.wdist = DistW'(w[17:0]);
			1: c.wdist = '1;
			default: c.wdist = w[DistW-1:0];
		endcase
		case ($urandom_range(0, 7))
			0: c.old = '0;
			1: c.old = '1;
			default: c.old = $urandom;
		endcase
		return c;
	endfunction

	task automatic send_cell(input cell_req_t c);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		vel_x <= c.vx;
		vel_y <= c.vy;
		vel_z <= c.vz;
		wall_dist <= c.wdist;
		old_visc <= c.old;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		visc_expected.push_back(predict_visc(c));
		cells_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (visc_expected.size() != 0);
	endtask

	task automatic set_reg(input logic [IdxW-1:0] idx, input logic [RelaxW-1:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == REG_RELAX)
			relax_q = data;
		else if (idx == REG_PROP)
			prop_q = data[ConstW-1:0];
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_cell(mk_cell('0, '0, '0, '0, '0));
		send_cell(mk_cell(24'sh010000, -24'sh020000, 24'sh008000, 24'h018000, 32'h0003_0000));
		send_cell(mk_cell(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '1, '0));
	endtask

	task automatic test_field_extremes();
		send_cell(mk_cell(24'sh800000, '0, '0, '1, 32'h1234_5678));
		send_cell(mk_cell('0, 24'sh800000, '0, '1, '1));
		send_cell(mk_cell('0, '0, 24'sh800000, 24'h000001, '0));
		send_cell(mk_cell(24'sh800000, 24'sh800000, 24'sh800000, '1, '1));
		set_reg(REG_PROP, 17'd65535);
		send_cell(mk_cell(24'sh800000, 24'sh7FFFFF, 24'sh800000, '1, '1));
		set_reg(REG_RELAX, 17'd0);
		send_cell(mk_cell(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '1, '1));
		send_cell(mk_cell(24'sh7FFFFF, '0, '0, '1, '0));
		set_reg(REG_RELAX, 17'd32768);
		// half weight on odd sums exercises the round-half-up path
		send_cell(mk_cell('0, '0, '0, '0, 32'h0000_0001));
		send_cell(mk_cell(24'sh7FFFFF, -24'sh7FFFFF, 24'sh800000, '1, '1));
	endtask

	task automatic test_reg_sweep();
		logic [RelaxW-1:0] relax_pts[6];
		logic [RelaxW-1:0] prop_pts[3];
		relax_pts = '{17'd1, 17'd32767, 17'd65535, 17'd65536, 17'd65537, 17'h1FFFF};
		prop_pts = '{17'd0, 17'd1, 17'd65535};
		foreach (relax_pts[i]) begin
			set_reg(REG_RELAX, relax_pts[i]);
			send_cell(rand_cell());
		end
		set_reg(REG_RELAX, 17'd40000);
		foreach (prop_pts[i]) begin
			set_reg(REG_PROP, prop_pts[i]);
			send_cell(rand_cell());
		end
	endtask

	task automatic test_bad_index();
		set_reg(REG_SPARE2, 17'd0);
		send_cell(rand_cell());
		set_reg(REG_SPARE3, 17'h1FFFF);
		send_cell(rand_cell());
	endtask

	task automatic test_backpressure();
		set_reg(REG_RELAX, 17'd12345);
		set_reg(REG_PROP, PROP_RST);
		tx_gaps = 1'b0;
		hold_req <= 1'b1;
		repeat (80)
			send_cell(rand_cell());
		drain();
		tx_gaps = 1'b1;
	endtask

	task automatic test_random(input int n_phases, input int per_phase);
		logic [RelaxW-1:0] r;
		logic [RelaxW-1:0] k;
		for (int p = 0; p < n_phases; p++) begin
			case ($urandom_range(0, 3))
				0: r = 17'd0;
				1: r = ONE_Q16;
				2: r = 17'($urandom_range(65537, 131071));
				default: r = 17'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 3))
				0: k = 17'd65535;
				1: k = 17'($urandom_range(0, 15));
				default: k = 17'($urandom_range(0, 65535));
			endcase
			set_reg(REG_RELAX, r);
			set_reg(REG_PROP, k);
			if (p == n_phases - 1) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			repeat (per_phase)
				send_cell(rand_cell());
		end
		drain();
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (visc_expected.size() == 0) begin
				$display("%0t unexpected result: expected none, actual new_visc=%h saturated=%b",
					$time, new_visc, saturated);
				mismatches++;
			end else begin
				head_res = visc_expected.pop_front();
				if (new_visc !== head_res.visc) begin
					$display("%0t new_visc mismatch: expected %h actual %h",
						$time, head_res.visc, new_visc);
					mismatches++;
				end
				if (saturated !== head_res.sat) begin
					$display("%0t saturated mismatch: expected %b actual %b",
						$time, head_res.sat, saturated);
					mismatches++;
				end
				cells_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t no progress for %0d cycles, %0d results outstanding",
					$time, idle_cycles, visc_expected.size());
				$display("eddy_viscosity_update verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		vel_x <= '0;
		vel_y <= '0;
		vel_z <= '0;
		wall_dist <= '0;
		old_visc <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_RELAX;
		cfg_wdata <= '0;
		hold_req <= 1'b0;
		relax_q = RELAX_RST;
		prop_q = PROP_RST;
		mismatches = 0;
		cells_sent = 0;
		cells_checked = 0;
		reg_writes = 0;
		idle_cycles = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_reg_sweep();
		test_bad_index();
		test_backpressure();
		test_random(6, 310);

		drain();
		repeat (PIPE_LAT + 8) @(posedge clk);
		$display("%0d cells sent, %0d results checked, %0d register writes", cells_sent,
			cells_checked, reg_writes);
		$display("covered reset defaults, field extremes, relax 0..above 1, spare indexes, long stall");
		if (mismatches == 0 && visc_expected.size() == 0) begin
			$display("eddy_viscosity_update verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				visc_expected.size());
			$display("eddy_viscosity_update verification failed");
		end
		$finish;
	end

endmodule
